// ----- design/smw_pkg.sv -----
// ----------------------------------------------------------------------------
// smw_pkg
// Shared types, register indexes, widths and reset values for the scan median
// and window offset block.
// ----------------------------------------------------------------------------
package smw_pkg;

  // Default sizing of the sample store.
  localparam int unsigned MaxScanLengthDef = 8192;
  localparam int unsigned SampleBitsDef    = 16;

  // Configuration register widths.
  localparam int unsigned TrigW    = 16;
  localparam int unsigned LeadW    = 13;
  localparam int unsigned WinW     = 14;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Width of the window start result field.
  localparam int unsigned StartW = 13;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgTriggerLevel = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLeadInCount  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWindowLength = 2'd2;

  // Register reset values.
  localparam logic [TrigW-1:0] TriggerLevelRst = 16'd25000;
  localparam logic [LeadW-1:0] LeadInCountRst  = 13'd200;
  localparam logic [WinW-1:0]  WindowLengthRst = 14'd1000;

  typedef enum logic [1:0] {
    SMW_LOAD,
    SMW_INIT,
    SMW_SCAN,
    SMW_FIN
  } smw_state_e;

endpackage

// ----- design/smw_scan_if.sv -----
// ----------------------------------------------------------------------------
// smw_scan_if
// Sample channel: one scan sample per transaction with an end-of-scan mark.
// ----------------------------------------------------------------------------
interface smw_scan_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// ----- design/smw_result_if.sv -----
// ----------------------------------------------------------------------------
// smw_result_if
// Result channel: median, window start and crossing flag of one scan.
// ----------------------------------------------------------------------------
interface smw_result_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  import smw_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] median_value;
  logic [StartW-1:0]      window_start;
  logic                   crossed;

  modport source (output valid, output median_value, output window_start,
                  output crossed, input ready);
  modport sink   (input valid, input median_value, input window_start,
                  input crossed, output ready);
endinterface

// ----- design/smw_cfg_if.sv -----
// ----------------------------------------------------------------------------
// smw_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface smw_cfg_if;
  import smw_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_idx;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

// ----- design/scan_median_and_window_offset.sv -----
// ----------------------------------------------------------------------------
// scan_median_and_window_offset
// Stores one scan of samples, notes the first threshold crossing and, at the
// end of the scan, reports the median and the start of the capture window.
// ----------------------------------------------------------------------------
//  Channel    Dir  Transaction
//  scan_i     in   one sample, last marks the end of the scan
//  result_o   out  median_value, window_start, crossed (one per scan)
//  cfg_i      in   register write: reg_idx, wdata (always ready)
//
//  Samples are taken one per cycle, but only in the load state. After the final
//  sample the median is found by a bitwise radix selection: SAMPLE_BITS passes
//  over the n stored samples, one read of the single-port sample memory per
//  cycle. Both middle elements are selected in the same passes. The result
//  waits in an output register; the next scan loads meanwhile and only its
//  final step stalls while the result is not taken. Reset needs no clearing
//  pass; only entries written in the scan are read.
// ----------------------------------------------------------------------------
module scan_median_and_window_offset #(
  parameter int unsigned MAX_SCAN_LENGTH = smw_pkg::MaxScanLengthDef,
  parameter int unsigned SAMPLE_BITS     = smw_pkg::SampleBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  smw_scan_if.sink       scan_i,
  smw_result_if.source   result_o,
  smw_cfg_if.sink        cfg_i
);
  import smw_pkg::*;

  localparam int unsigned IdxW  = $clog2(MAX_SCAN_LENGTH);
  localparam int unsigned CntW  = $clog2(MAX_SCAN_LENGTH + 1);
  localparam int unsigned PassW = $clog2(SAMPLE_BITS);
  localparam int unsigned LvlW  = (SAMPLE_BITS > TrigW) ? SAMPLE_BITS : TrigW;
  localparam int unsigned CmpW  = (CntW > WinW) ? CntW : WinW;
  localparam int unsigned OffW  = (IdxW > LeadW) ? IdxW : LeadW;

  // Configuration registers.
  logic [TrigW-1:0] trig_q;
  logic [LeadW-1:0] lead_q;
  logic [WinW-1:0]  win_q;

  // Scan state.
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] cidx_q;
  logic            seen_q;

  // Sample memory.
  logic [SAMPLE_BITS-1:0] mem [MAX_SCAN_LENGTH];
  logic [SAMPLE_BITS-1:0] rdata_q;

  // Read issue side.
  logic             issue_q;
  logic [IdxW-1:0]  iaddr_q;
  logic [PassW-1:0] ipass_q;
  logic             rd_vld_q;
  logic             rd_last_q;
  logic             rd_final_q;

  // Selection side: A selects the lower middle element, B the upper.
  logic [SAMPLE_BITS-1:0] bsel_q;
  logic [SAMPLE_BITS-1:0] hmask_q;
  logic [SAMPLE_BITS-1:0] res_a_q, res_b_q;
  logic [CntW-1:0]        k_a_q, k_b_q;
  logic [CntW-1:0]        z_a_q, z_b_q;

  // Output register.
  logic                   out_vld_q;
  logic [SAMPLE_BITS-1:0] out_med_q;
  logic [StartW-1:0]      out_start_q;
  logic                   out_cross_q;

  smw_state_e state_q, state_d;
  logic       scan_acc;
  logic       out_load;
  logic       cnt_full;
  logic       store_en;
  logic [CntW-1:0] cnt_m1;
  logic [CntW-1:0] half;
  logic [IdxW-1:0] last_addr;
  logic       iaddr_end;
  logic       match_a, match_b;
  logic [CntW-1:0] z_a_sum, z_b_sum;
  logic [SAMPLE_BITS:0] med_sum;
  logic [OffW-1:0] start_diff;
  logic       windowed;

  assign cfg_i.ready    = 1'b1;
  assign scan_i.ready   = (state_q == SMW_LOAD);
  assign scan_acc       = scan_i.valid && scan_i.ready;
  assign cnt_full       = (cnt_q == CntW'(MAX_SCAN_LENGTH));
  assign store_en       = scan_acc && !cnt_full;
  assign cnt_m1         = cnt_q - CntW'(1);
  assign half           = cnt_q >> 1;
  assign last_addr      = cnt_m1[IdxW-1:0];
  assign iaddr_end      = (iaddr_q == last_addr);

  // A stored sample counts towards the zeros of this bit when it agrees with
  // the selected prefix above the bit and has a zero at the bit.
  assign match_a = (((rdata_q ^ res_a_q) & hmask_q) == '0) && ((rdata_q & bsel_q) == '0);
  assign match_b = (((rdata_q ^ res_b_q) & hmask_q) == '0) && ((rdata_q & bsel_q) == '0);
  assign z_a_sum = z_a_q + CntW'(match_a);
  assign z_b_sum = z_b_q + CntW'(match_b);

  assign med_sum    = {1'b0, res_a_q} + {1'b0, res_b_q};
  assign start_diff = OffW'(cidx_q) - OffW'(lead_q);
  assign windowed   = seen_q && (CmpW'(cnt_q) > CmpW'(win_q));

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= TriggerLevelRst;
      lead_q <= LeadInCountRst;
      win_q  <= WindowLengthRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.reg_idx)
        CfgTriggerLevel: trig_q <= cfg_i.wdata[TrigW-1:0];
        CfgLeadInCount:  lead_q <= cfg_i.wdata[LeadW-1:0];
        CfgWindowLength: win_q  <= cfg_i.wdata[WinW-1:0];
        default: ;
      endcase
    end
  end

  // Control state machine.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SMW_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      SMW_LOAD: begin
        if (scan_acc && scan_i.last) begin
          state_d = SMW_INIT;
        end
      end
      SMW_INIT: begin
        state_d = SMW_SCAN;
      end
      SMW_SCAN: begin
        if (rd_vld_q && rd_final_q) begin
          state_d = SMW_FIN;
        end
      end
      SMW_FIN: begin
        if (!out_vld_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = SMW_LOAD;
        end
      end
      default: state_d = SMW_LOAD;
    endcase
  end

  // Scan count and first crossing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cidx_q <= '0;
      seen_q <= 1'b0;
    end else if (out_load) begin
      cnt_q  <= '0;
      cidx_q <= '0;
      seen_q <= 1'b0;
    end else if (store_en) begin
      cnt_q <= cnt_q + CntW'(1);
      if (!seen_q && (LvlW'(scan_i.sample) >= LvlW'(trig_q))) begin
        seen_q <= 1'b1;
        cidx_q <= cnt_q[IdxW-1:0];
      end
    end
  end

  // Sample memory: written while loading, read during the selection passes.
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem[cnt_q[IdxW-1:0]] <= scan_i.sample;
    end
    if (issue_q) begin
      rdata_q <= mem[iaddr_q];
    end
  end

  // Read issue: SAMPLE_BITS sweeps over addresses 0 to n-1, back to back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q    <= 1'b0;
      iaddr_q    <= '0;
      ipass_q    <= '0;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      rd_final_q <= 1'b0;
    end else begin
      rd_vld_q   <= issue_q;
      rd_last_q  <= issue_q && iaddr_end;
      rd_final_q <= issue_q && iaddr_end && (ipass_q == '0);
      if (state_q == SMW_INIT) begin
        issue_q <= 1'b1;
        iaddr_q <= '0;
        ipass_q <= PassW'(SAMPLE_BITS - 1);
      end else if (issue_q) begin
        if (iaddr_end) begin
          iaddr_q <= '0;
          if (ipass_q == '0) begin
            issue_q <= 1'b0;
          end else begin
            ipass_q <= ipass_q - PassW'(1);
          end
        end else begin
          iaddr_q <= iaddr_q + IdxW'(1);
        end
      end
    end
  end

  // Radix selection: count zeros under the current prefix, then decide the bit.
  always_ff @(posedge clk_i) begin
    if (state_q == SMW_INIT) begin
      bsel_q  <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      hmask_q <= '0;
      res_a_q <= '0;
      res_b_q <= '0;
      z_a_q   <= '0;
      z_b_q   <= '0;
      k_b_q   <= half;
      k_a_q   <= cnt_q[0] ? half : half - CntW'(1);
    end else if (rd_vld_q) begin
      if (rd_last_q) begin
        z_a_q   <= '0;
        z_b_q   <= '0;
        bsel_q  <= bsel_q >> 1;
        hmask_q <= {1'b1, hmask_q[SAMPLE_BITS-1:1]};
        if (k_a_q >= z_a_sum) begin
          k_a_q   <= k_a_q - z_a_sum;
          res_a_q <= res_a_q | bsel_q;
        end
        if (k_b_q >= z_b_sum) begin
          k_b_q   <= k_b_q - z_b_sum;
          res_b_q <= res_b_q | bsel_q;
        end
      end else begin
        z_a_q <= z_a_sum;
        z_b_q <= z_b_sum;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_med_q   <= med_sum[SAMPLE_BITS:1];
      out_cross_q <= seen_q;
      if (windowed && (OffW'(cidx_q) > OffW'(lead_q))) begin
        out_start_q <= start_diff[StartW-1:0];
      end else begin
        out_start_q <= '0;
      end
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.median_value = out_med_q;
  assign result_o.window_start = out_start_q;
  assign result_o.crossed      = out_cross_q;

endmodule

// ----- tb/tb_scan_median_and_window_offset.sv -----
// ----------------------------------------------------------------------------
// tb_scan_median_and_window_offset
// Drives scans of samples into the median and window offset block, predicts
// the median, window start and crossing flag of every scan, and compares each
// result transaction with the oldest prediction. Register settings change
// between phases while the block is idle. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_scan_median_and_window_offset;
  timeunit 1ns;
  timeprecision 1ps;

  import smw_pkg::*;

  localparam int unsigned StoreDepth    = MaxScanLengthDef;
  localparam int unsigned SampleW       = SampleBitsDef;
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;
  localparam int unsigned IdlePct       = 20;
  localparam int unsigned DrainQuiet    = 8;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned RandomItems   = 500;
  localparam int unsigned RandomPhases  = 6;

  typedef enum int unsigned {
    MixWide,
    MixNearTrigger,
    MixFewValues,
    MixNarrow
  } sample_mix_e;

  typedef struct packed {
    logic [SampleW-1:0] median;
    logic [StartW-1:0]  start;
    logic               crossed;
  } scan_summary_t;

  class median_window_tracker;
    logic [TrigW-1:0]   trigger_level;
    logic [LeadW-1:0]   lead_in;
    logic [WinW-1:0]    window_len;
    logic [SampleW-1:0] stored[$];
    logic [StartW-1:0]  cross_at;
    bit                 cross_hit;
    scan_summary_t      summaries_due[$];
    int unsigned        mismatches;

    function new();
      trigger_level = TriggerLevelRst;
      lead_in       = LeadInCountRst;
      window_len    = WindowLengthRst;
      cross_at      = '0;
      cross_hit     = 1'b0;
      mismatches    = 0;
    endfunction

    function void apply_reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgTriggerLevel: trigger_level = data[TrigW-1:0];
        CfgLeadInCount:  lead_in       = data[LeadW-1:0];
        CfgWindowLength: window_len    = data[WinW-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic [SampleW-1:0] s, logic last);
      logic [SampleW-1:0] sorted[$];
      logic [SampleW:0]   pair_sum;
      int unsigned        n;
      scan_summary_t      summary;
      // Once the store is full, further samples are dropped without a test.
      if (stored.size() < StoreDepth) begin
        if (!cross_hit && s >= trigger_level) begin
          cross_hit = 1'b1;
          cross_at  = StartW'(stored.size());
        end
        stored.push_back(s);
      end
      if (!last) return;
      n = stored.size();
      sorted = stored;
      sorted.sort();
      if (n % 2 == 1) begin
        summary.median = sorted[n / 2];
      end else begin
        pair_sum = {1'b0, sorted[n / 2 - 1]} + {1'b0, sorted[n / 2]};
        summary.median = pair_sum[SampleW:1];
      end
      summary.start = '0;
      if (cross_hit && n > window_len) begin
        summary.start = (cross_at > lead_in) ? cross_at - lead_in : '0;
      end
      summary.crossed = cross_hit;
      summaries_due.push_back(summary);
      stored.delete();
      cross_at  = '0;
      cross_hit = 1'b0;
    endfunction

    function void match_result(logic [SampleW-1:0] m, logic [StartW-1:0] w, logic c);
      scan_summary_t due;
      if (summaries_due.size() == 0) begin
        $error("result transaction with no scan pending: median_value %0d window_start %0d crossed %0d",
               m, w, c);
        mismatches++;
        return;
      end
      due = summaries_due.pop_front();
      if (m !== due.median) begin
        $error("median_value: expected %0d, actual %0d", due.median, m);
        mismatches++;
      end
      if (w !== due.start) begin
        $error("window_start: expected %0d, actual %0d", due.start, w);
        mismatches++;
      end
      if (c !== due.crossed) begin
        $error("crossed: expected %0d, actual %0d", due.crossed, c);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;
  bit   hold_request;

  median_window_tracker tracker = new();

  smw_scan_if #(.SAMPLE_BITS(SampleW))   scan_ch ();
  smw_result_if #(.SAMPLE_BITS(SampleW)) res_ch ();
  smw_cfg_if                             cfg_ch ();

  scan_median_and_window_offset dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .scan_i   (scan_ch),
    .result_o (res_ch),
    .cfg_i    (cfg_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("FAIL scan_median_and_window_offset");
    $finish;
  end

  // Result side: checks every result transaction and decides the next ready.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) begin
        tracker.match_result(res_ch.median_value, res_ch.window_start, res_ch.crossed);
      end
      if (hold_request) begin
        hold_left    = HoldOffCycles;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // The write is followed by one cycle with valid low, so that back-to-back
  // writes never lower and raise valid in the same time step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.reg_idx <= idx;
    cfg_ch.wdata   <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    tracker.apply_reg_write(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_sample(input logic [SampleW-1:0] s, input logic last);
    scan_ch.valid  <= 1'b1;
    scan_ch.sample <= s;
    scan_ch.last   <= last;
    do @(posedge clk_i); while (!scan_ch.ready);
    tracker.take_sample(s, last);
    if (!calm && $urandom_range(99) < IdlePct) begin
      scan_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // Waits until every scan has reported, then lets the block go quiet.
  task automatic settle();
    scan_ch.valid <= 1'b0;
    while (tracker.summaries_due.size() != 0) @(posedge clk_i);
    repeat (DrainQuiet) @(posedge clk_i);
  endtask

  function automatic logic [SampleW-1:0] pick_sample(sample_mix_e mix);
    int near;
    case (mix)
      MixWide: return SampleW'($urandom);
      MixNearTrigger: begin
        near = int'(tracker.trigger_level) + int'($urandom_range(6)) - 3;
        if (near < 0) near = 0;
        else if (near > 65535) near = 65535;
        return SampleW'(near);
      end
      MixFewValues: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return tracker.trigger_level;
          default: return 16'h8000;
        endcase
      end
      default: return SampleW'($urandom_range(15));
    endcase
  endfunction

  task automatic push_scan(input int unsigned len, input sample_mix_e mix);
    for (int unsigned i = 0; i < len; i++) begin
      push_sample(pick_sample(mix), i == len - 1);
    end
  endtask

  task automatic random_config();
    logic [CfgDataW-1:0] v;
    case ($urandom_range(3))
      0: v = '0;
      1: v = '1;
      default: v = CfgDataW'($urandom);
    endcase
    write_reg(CfgTriggerLevel, v);
    case ($urandom_range(3))
      0: v = '0;
      1: v = 16'd8191;
      2: v = CfgDataW'($urandom_range(8));
      default: v = CfgDataW'($urandom);
    endcase
    write_reg(CfgLeadInCount, v);
    // Small window lengths are favoured so that the window start is non-zero.
    case ($urandom_range(5))
      0: v = '0;
      1: v = 16'd1;
      2, 3: v = CfgDataW'($urandom_range(20));
      4: v = 16'd8192;
      default: v = CfgDataW'($urandom);
    endcase
    write_reg(CfgWindowLength, v);
  endtask

  task automatic random_scans(input int unsigned items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 1);
      push_scan(len, sample_mix_e'($urandom_range(3)));
      sent += len;
    end
  endtask

  // A scan longer than the store. With a crossing in the store, the dropped
  // tail is all zeros; without one, the tail would cross if it were tested.
  task automatic overlong_scan(input bit cross_in_store);
    logic [SampleW-1:0] s;
    for (int unsigned i = 0; i < StoreDepth + 24; i++) begin
      if (i >= StoreDepth) s = cross_in_store ? '0 : '1;
      else if (cross_in_store && i == StoreDepth - 2) s = '1;
      else s = SampleW'($urandom_range(60000));
      push_sample(s, i == StoreDepth + 23);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    calm           = 1'b0;
    hold_request   = 1'b0;
    scan_ch.valid  = 1'b0;
    scan_ch.sample = '0;
    scan_ch.last   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.reg_idx = CfgTriggerLevel;
    cfg_ch.wdata   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-sample scans, even lengths with a wide and a saturating pair,
    // and a sample exactly at the reset trigger level.
    push_sample(16'd0, 1'b1);
    push_sample(16'hFFFF, 1'b1);
    push_sample(16'd0, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'hFFFF, 1'b1);
    push_sample(16'd30000, 1'b0);
    push_sample(16'd100, 1'b0);
    push_sample(16'd25000, 1'b1);
    push_sample(16'd24999, 1'b0);
    push_sample(16'd1, 1'b0);
    push_sample(16'd25000, 1'b0);
    push_sample(16'd7, 1'b1);
    settle();

    // A zero window length windows every crossing scan; an unmapped index
    // must leave all registers alone.
    write_reg(CfgTriggerLevel, 16'd0);
    write_reg(CfgLeadInCount, 16'd0);
    write_reg(CfgWindowLength, 16'd0);
    write_reg(CfgUnmapped, 16'hFFFF);
    push_sample(16'd5, 1'b0);
    push_sample(16'd9, 1'b0);
    push_sample(16'd2, 1'b1);
    settle();

    write_reg(CfgTriggerLevel, 16'd100);
    write_reg(CfgLeadInCount, 16'd1);
    write_reg(CfgWindowLength, 16'd2);
    push_sample(16'd10, 1'b0);
    push_sample(16'd20, 1'b0);
    push_sample(16'd300, 1'b0);
    push_sample(16'd5, 1'b0);
    push_sample(16'd400, 1'b1);
    settle();

    // Write data wider than the lead-in and window registers, trigger at its top.
    write_reg(CfgTriggerLevel, 16'hFFFF);
    write_reg(CfgLeadInCount, 16'hFFFF);
    write_reg(CfgWindowLength, 16'hFFFF);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'hFFFE, 1'b1);
    settle();

    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      random_config();
      calm = (phase == 2);
      if (phase == 3) begin
        // The result side holds off while short scans keep arriving, so the
        // block fills up and stalls the sample channel.
        hold_request = 1'b1;
        repeat (8) push_scan(3, MixWide);
      end
      random_scans(RandomItems / RandomPhases);
      settle();
    end
    calm = 1'b0;

    write_reg(CfgTriggerLevel, 16'hFFFF);
    write_reg(CfgLeadInCount, 16'd0);
    write_reg(CfgWindowLength, 16'd1);
    calm = 1'b1;
    overlong_scan(1'b1);
    overlong_scan(1'b0);
    calm = 1'b0;

    settle();
    repeat (50) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("PASS scan_median_and_window_offset");
    end else begin
      $display("FAIL scan_median_and_window_offset");
    end
    $finish;
  end

endmodule
